// ===== rtl/brp_pkg.sv =====
// ---------------------------------------------------------------------------
// brp_pkg: shared types and constants for the BAM record parser
// Result kinds, error codes, parse phases and the base decode table.
// ---------------------------------------------------------------------------
package brp_pkg;

	localparam int FIFO_DEPTH = 4;

	typedef enum logic [3:0] {
		K_FIXED     = 4'd0,
		K_NAME      = 4'd1,
		K_CIGAR     = 4'd2,
		K_BASE      = 4'd3,
		K_QUAL      = 4'd4,
		K_QUAL_NA   = 4'd5,
		K_REC_END   = 4'd6,
		K_CLEAN_END = 4'd7,
		K_ERROR     = 4'd8
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE      = 3'd0,
		E_TRUNC     = 3'd1,
		E_SMALL     = 3'd2,
		E_EMPTYNAME = 3'd3,
		E_NEGLEN    = 3'd4,
		E_OVERFLOW  = 3'd5,
		E_BADOP     = 3'd6
	} err_t;

	typedef enum logic [2:0] {
		PH_SIZE  = 3'd0,
		PH_FIXED = 3'd1,
		PH_NAME  = 3'd2,
		PH_CIGAR = 3'd3,
		PH_SEQ   = 3'd4,
		PH_QUAL  = 3'd5,
		PH_TAGS  = 3'd6
	} phase_t;

	// one result: 4+3+32+4+8+3+1 bits
	typedef struct packed {
		logic        last;
		err_t        err;
		logic [7:0]  ch;
		logic [3:0]  op;
		logic [31:0] value;
		logic [2:0]  fid;
		kind_t       kind;
	} res_t;

	// up to three results from one byte
	typedef struct packed {
		logic [1:0] count;
		res_t       r2;
		res_t       r1;
		res_t       r0;
	} bundle_t;

	localparam logic [7:0] QUAL_NA_BYTE = 8'hFF;
	localparam logic [7:0] PHRED_OFFSET = 8'd33;
	localparam logic [31:0] FIXED_LEN   = 32'd32;

	function automatic logic [7:0] base_char(input logic [3:0] nib);
		logic [7:0] c;
		case (nib)
			4'd0:  c = "=";
			4'd1:  c = "A";
			4'd2:  c = "C";
			4'd3:  c = "M";
			4'd4:  c = "G";
			4'd5:  c = "R";
			4'd6:  c = "S";
			4'd7:  c = "V";
			4'd8:  c = "T";
			4'd9:  c = "W";
			4'd10: c = "Y";
			4'd11: c = "H";
			4'd12: c = "K";
			4'd13: c = "D";
			4'd14: c = "B";
			default: c = "N";
		endcase
		return c;
	endfunction

	function automatic res_t mk(input kind_t k, input logic [2:0] f, input logic [31:0] v,
			input logic [3:0] o, input logic [7:0] c, input err_t e);
		res_t r;
		r.last  = 1'b0;
		r.kind  = k;
		r.fid   = f;
		r.value = v;
		r.op    = o;
		r.ch    = c;
		r.err   = e;
		return r;
	endfunction

endpackage

// ===== rtl/brp_front.sv =====
// ---------------------------------------------------------------------------
// brp_front: byte classifier
// Tracks the record layout and turns each byte into a bundle of results.
// ---------------------------------------------------------------------------
module brp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic              end_of_input,
	output logic              b_valid,
	input  logic              b_ready,
	output brp_pkg::bundle_t  b_data
);

	brp_pkg::phase_t phase_q;
	logic [1:0]  biw_q;
	logic [31:0] word_q;
	logic [31:0] block_left_q;
	logic [7:0]  name_len_q;
	logic [7:0]  name_left_q;
	logic [15:0] cigar_left_q;
	logic [30:0] seq_len_q;
	logic [30:0] items_left_q;
	logic        qskip_q;
	logic        halted_q;
	logic [18:0] fix_sum_q;

	// layout check: name and cigar part registered one byte ahead, l_seq added at byte 19
	logic [33:0] var_sum;
	logic        ovf;

	brp_pkg::phase_t phase_d;
	logic [1:0]  biw_d;
	logic [31:0] word_d;
	logic [31:0] block_left_d;
	logic [7:0]  name_len_d, name_left_d;
	logic [15:0] cigar_left_d;
	logic [30:0] seq_len_d, items_left_d;
	logic        qskip_d, halted_d;
	brp_pkg::res_t r [3];
	logic [1:0]  cnt;
	logic [31:0] gw;
	logic [31:0] bl_dec;
	logic [4:0]  off;
	logic [30:0] il_dec;
	logic        acc;

	assign in_ready = b_ready;
	assign acc = in_valid && in_ready;
	assign gw = (biw_q == 2'd0) ? {24'd0, data_byte} :
		(word_q | ({24'd0, data_byte} << {biw_q, 3'b000}));
	assign bl_dec = block_left_q - 32'd1;
	assign off = 5'(6'd32 - items_left_q[5:0]);
	assign il_dec = items_left_q - 31'd1;

	// name plus four bytes per cigar word plus the 12 bytes that follow l_seq
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_sum_q <= '0;
		end else if (acc && phase_q == brp_pkg::PH_FIXED) begin
			fix_sum_q <= {11'd0, name_len_q} + {1'b0, cigar_left_q, 2'b00} + 19'd12;
		end
	end

	// add packed and quality bytes of l_seq and compare with the bytes left
	always_comb begin
		var_sum = {15'd0, fix_sum_q} + {3'd0, gw[30:0]} + {4'd0, gw[30:1]}
			+ {33'd0, gw[0]};
		ovf = var_sum > {2'd0, bl_dec};
	end

	// phase update and result generation
	always_comb begin
		phase_d = phase_q; biw_d = biw_q; word_d = word_q; block_left_d = block_left_q;
		name_len_d = name_len_q; name_left_d = name_left_q; cigar_left_d = cigar_left_q;
		seq_len_d = seq_len_q; items_left_d = items_left_q; qskip_d = qskip_q;
		halted_d = halted_q;
		cnt = 2'd0;
		for (int i = 0; i < 3; i++) begin
			r[i] = '0;
		end
		if (halted_q) begin
			cnt = 2'd0;
		end else if (end_of_input) begin
			halted_d = 1'b1;
			cnt = 2'd1;
			if (phase_q == brp_pkg::PH_SIZE && biw_q == 2'd0) begin
				r[0] = brp_pkg::mk(brp_pkg::K_CLEAN_END, 3'd0, 32'd0, 4'd0, 8'd0,
					brp_pkg::E_NONE);
			end else begin
				r[0] = brp_pkg::mk(brp_pkg::K_ERROR, 3'd0, 32'd0, 4'd0, 8'd0,
					brp_pkg::E_TRUNC);
			end
		end else if (phase_q == brp_pkg::PH_SIZE) begin
			word_d = gw;
			biw_d = biw_q + 2'd1;
			if (biw_q == 2'd3) begin
				if (gw < brp_pkg::FIXED_LEN) begin
					halted_d = 1'b1;
					cnt = 2'd1;
					r[0] = brp_pkg::mk(brp_pkg::K_ERROR, 3'd0, 32'd0, 4'd0, 8'd0,
						brp_pkg::E_SMALL);
				end else begin
					block_left_d = gw;
					phase_d = brp_pkg::PH_FIXED;
					items_left_d = 31'd32;
				end
			end
		end else begin
			block_left_d = bl_dec;
			case (phase_q)
				brp_pkg::PH_FIXED: begin
					word_d = gw;
					biw_d = biw_q + 2'd1;
					items_left_d = il_dec;
					case (off)
						5'd3:  begin cnt = 2'd1; r[0] = brp_pkg::mk(brp_pkg::K_FIXED, 3'd0,
							gw, 4'd0, 8'd0, brp_pkg::E_NONE); end
						5'd7:  begin cnt = 2'd1; r[0] = brp_pkg::mk(brp_pkg::K_FIXED, 3'd1,
							gw, 4'd0, 8'd0, brp_pkg::E_NONE); end
						5'd8:  name_len_d = data_byte;
						5'd9:  begin cnt = 2'd1; r[0] = brp_pkg::mk(brp_pkg::K_FIXED, 3'd2,
							{24'd0, data_byte}, 4'd0, 8'd0, brp_pkg::E_NONE); end
						5'd13: cigar_left_d = gw[15:0];
						5'd15: begin cnt = 2'd1; r[0] = brp_pkg::mk(brp_pkg::K_FIXED, 3'd3,
							{16'd0, gw[31:16]}, 4'd0, 8'd0, brp_pkg::E_NONE); end
						5'd19: begin
							if (name_len_q == 8'd0 || gw[31] || ovf) begin
								cnt = 2'd1;
								halted_d = 1'b1;
								r[0] = brp_pkg::mk(brp_pkg::K_ERROR, 3'd0, 32'd0, 4'd0,
									8'd0, (name_len_q == 8'd0) ? brp_pkg::E_EMPTYNAME :
									(gw[31] ? brp_pkg::E_NEGLEN : brp_pkg::E_OVERFLOW));
							end
							seq_len_d = gw[30:0];
						end
						5'd23: begin cnt = 2'd1; r[0] = brp_pkg::mk(brp_pkg::K_FIXED, 3'd4,
							gw, 4'd0, 8'd0, brp_pkg::E_NONE); end
						5'd27: begin cnt = 2'd1; r[0] = brp_pkg::mk(brp_pkg::K_FIXED, 3'd5,
							gw, 4'd0, 8'd0, brp_pkg::E_NONE); end
						5'd31: begin
							cnt = 2'd1;
							r[0] = brp_pkg::mk(brp_pkg::K_FIXED, 3'd6, gw, 4'd0, 8'd0,
								brp_pkg::E_NONE);
							phase_d = brp_pkg::PH_NAME;
							name_left_d = name_len_q;
						end
						default: ;
					endcase
				end
				brp_pkg::PH_NAME: begin
					name_left_d = name_left_q - 8'd1;
					if (!(name_left_d == 8'd0 && data_byte == 8'd0)) begin
						cnt = 2'd1;
						r[0] = brp_pkg::mk(brp_pkg::K_NAME, 3'd0, 32'd0, 4'd0, data_byte,
							brp_pkg::E_NONE);
					end
					if (name_left_d == 8'd0) begin
						// skip empty cigar, sequence and tag sections in this byte
						if (cigar_left_q != 16'd0) begin
							phase_d = brp_pkg::PH_CIGAR;
							biw_d = 2'd0;
							word_d = 32'd0;
						end else if (seq_len_q != 31'd0) begin
							phase_d = brp_pkg::PH_SEQ;
							items_left_d = seq_len_q;
						end else begin
							r[cnt] = brp_pkg::mk(brp_pkg::K_QUAL_NA, 3'd0, 32'd0, 4'd0,
								8'd0, brp_pkg::E_NONE);
							cnt = cnt + 2'd1;
							if (bl_dec != 32'd0) begin
								phase_d = brp_pkg::PH_TAGS;
							end else begin
								r[cnt] = brp_pkg::mk(brp_pkg::K_REC_END, 3'd0, 32'd0,
									4'd0, 8'd0, brp_pkg::E_NONE);
								cnt = cnt + 2'd1;
								phase_d = brp_pkg::PH_SIZE;
								biw_d = 2'd0;
								word_d = 32'd0;
							end
						end
					end
				end
				brp_pkg::PH_CIGAR: begin
					word_d = gw;
					biw_d = biw_q + 2'd1;
					if (biw_q == 2'd3) begin
						if (gw[3:0] > 4'd8) begin
							cnt = 2'd1;
							halted_d = 1'b1;
							r[0] = brp_pkg::mk(brp_pkg::K_ERROR, 3'd0, 32'd0, 4'd0, 8'd0,
								brp_pkg::E_BADOP);
						end else begin
							cnt = 2'd1;
							r[0] = brp_pkg::mk(brp_pkg::K_CIGAR, 3'd0, {4'd0, gw[31:4]},
								gw[3:0], 8'd0, brp_pkg::E_NONE);
							cigar_left_d = cigar_left_q - 16'd1;
							if (cigar_left_d == 16'd0) begin
								if (seq_len_q != 31'd0) begin
									phase_d = brp_pkg::PH_SEQ;
									items_left_d = seq_len_q;
								end else begin
									r[1] = brp_pkg::mk(brp_pkg::K_QUAL_NA, 3'd0, 32'd0,
										4'd0, 8'd0, brp_pkg::E_NONE);
									cnt = 2'd2;
									if (bl_dec != 32'd0) begin
										phase_d = brp_pkg::PH_TAGS;
									end else begin
										r[2] = brp_pkg::mk(brp_pkg::K_REC_END, 3'd0, 32'd0,
											4'd0, 8'd0, brp_pkg::E_NONE);
										cnt = 2'd3;
										phase_d = brp_pkg::PH_SIZE;
										biw_d = 2'd0;
										word_d = 32'd0;
									end
								end
							end
						end
					end
				end
				brp_pkg::PH_SEQ: begin
					cnt = 2'd1;
					r[0] = brp_pkg::mk(brp_pkg::K_BASE, 3'd0, 32'd0, 4'd0,
						brp_pkg::base_char(data_byte[7:4]), brp_pkg::E_NONE);
					items_left_d = il_dec;
					if (il_dec != 31'd0) begin
						cnt = 2'd2;
						r[1] = brp_pkg::mk(brp_pkg::K_BASE, 3'd0, 32'd0, 4'd0,
							brp_pkg::base_char(data_byte[3:0]), brp_pkg::E_NONE);
						items_left_d = items_left_q - 31'd2;
					end
					if (items_left_d == 31'd0) begin
						phase_d = brp_pkg::PH_QUAL;
						items_left_d = seq_len_q;
						qskip_d = 1'b0;
					end
				end
				brp_pkg::PH_QUAL: begin
					if (items_left_q == seq_len_q && data_byte == brp_pkg::QUAL_NA_BYTE) begin
						cnt = 2'd1;
						r[0] = brp_pkg::mk(brp_pkg::K_QUAL_NA, 3'd0, 32'd0, 4'd0, 8'd0,
							brp_pkg::E_NONE);
						qskip_d = 1'b1;
					end else if (!qskip_q) begin
						cnt = 2'd1;
						r[0] = brp_pkg::mk(brp_pkg::K_QUAL, 3'd0, 32'd0, 4'd0,
							data_byte + brp_pkg::PHRED_OFFSET, brp_pkg::E_NONE);
					end
					items_left_d = il_dec;
					if (il_dec == 31'd0) begin
						if (bl_dec != 32'd0) begin
							phase_d = brp_pkg::PH_TAGS;
						end else begin
							r[cnt] = brp_pkg::mk(brp_pkg::K_REC_END, 3'd0, 32'd0, 4'd0,
								8'd0, brp_pkg::E_NONE);
							cnt = cnt + 2'd1;
							phase_d = brp_pkg::PH_SIZE;
							biw_d = 2'd0;
							word_d = 32'd0;
						end
					end
				end
				default: begin
					if (bl_dec == 32'd0) begin
						cnt = 2'd1;
						r[0] = brp_pkg::mk(brp_pkg::K_REC_END, 3'd0, 32'd0, 4'd0, 8'd0,
							brp_pkg::E_NONE);
						phase_d = brp_pkg::PH_SIZE;
						biw_d = 2'd0;
						word_d = 32'd0;
					end
				end
			endcase
		end
		if (cnt != 2'd0) begin
			r[cnt - 2'd1].last = 1'b1;
		end
	end

	// advance state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= brp_pkg::PH_SIZE;
			biw_q <= '0; word_q <= '0; block_left_q <= '0; name_len_q <= '0;
			name_left_q <= '0; cigar_left_q <= '0; seq_len_q <= '0;
			items_left_q <= '0; qskip_q <= 1'b0; halted_q <= 1'b0;
		end else if (acc) begin
			phase_q <= phase_d;
			biw_q <= biw_d; word_q <= word_d; block_left_q <= block_left_d;
			name_len_q <= name_len_d; name_left_q <= name_left_d;
			cigar_left_q <= cigar_left_d; seq_len_q <= seq_len_d;
			items_left_q <= items_left_d; qskip_q <= qskip_d; halted_q <= halted_d;
		end
	end

	assign b_valid = acc && (cnt != 2'd0);
	always_comb begin
		b_data.count = cnt;
		b_data.r0 = r[0];
		b_data.r1 = r[1];
		b_data.r2 = r[2];
	end

`ifndef NO_ASSERTIONS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q) else $error("halt flag cleared");
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !b_valid) else $error("bundle after halt");
	a_biw_size: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == brp_pkg::PH_NAME) |-> (biw_q == 2'd0)) else $error("word misaligned");
`endif

endmodule

// ===== rtl/brp_back.sv =====
// ---------------------------------------------------------------------------
// brp_back: result queue and serializer
// Queues result bundles and hands out one result item per cycle while o_ready is high.
// ---------------------------------------------------------------------------
module brp_back #(
	parameter int Depth = brp_pkg::FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              b_valid,
	output logic              b_ready,
	input  brp_pkg::bundle_t  b_data,
	output logic              o_valid,
	input  logic              o_ready,
	output brp_pkg::res_t     o_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	brp_pkg::bundle_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic [1:0]    sel_q;
	brp_pkg::bundle_t head;
	logic push, pop, take;

	assign head = mem_q[rp_q];
	assign b_ready = (cnt_q != AW'(0) + (AW+1)'(Depth));
	assign push = b_valid && b_ready;
	assign o_valid = (cnt_q != '0);
	assign take = o_valid && o_ready;
	assign pop = take && ((sel_q + 2'd1) == head.count);

	always_comb begin
		case (sel_q)
			2'd0: o_data = head.r0;
			2'd1: o_data = head.r1;
			default: o_data = head.r2;
		endcase
	end

	// store bundles
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= b_data;
		end
	end

	// advance pointers and result index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; sel_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
			if (pop) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
			if (pop) sel_q <= '0;
			else if (take) sel_q <= sel_q + 2'd1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == (AW+1)'(Depth)) |-> !push) else $error("queue overflow");
	a_sel_rng: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> (sel_q < head.count)) else $error("result index past bundle");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> o_data.last) else $error("bundle ends without last");
`endif

endmodule

// ===== rtl/bam_record_parser.sv =====
// ---------------------------------------------------------------------------
// bam_record_parser: BAM alignment record decoder
// Decodes decompressed BAM record bytes into fields, names, CIGAR, bases.
// ---------------------------------------------------------------------------
// Usage: feed stream bytes after the file header on s_axis, one per item;
// tuser=1 marks end of stream (tdata ignored). Results leave on m_axis,
// up to three per input byte, tuser carrying the result kind and tlast
// marking the last result of that byte.
// Each byte's bundle is registered in the queue when the byte is accepted.
// Throughput: one byte per cycle into a bundle queue while it has room; the
// output side drains one result per cycle while m_axis_tready is high, so
// sustained sequence input (two bases per byte) is bounded by the single result port.
// Reset clears the parser to await a block size; the queue empties.
// When m_axis stalls, the queue fills and s_axis_tready drops; nothing is lost.
// After an error or clean end the block drops all further bytes until reset.
// ---------------------------------------------------------------------------
module bam_record_parser #(
	parameter int Depth = brp_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [2:0] field_id, [34:3] value, [38:35] cigar_op,
	// [46:39] char_out, [49:47] error_code, [55:50] zero
	output logic [55:0] m_axis_tdata,
	output logic [3:0]  m_axis_tuser,   // [3:0] kind
	output logic        m_axis_tlast
);

	logic             b_valid, b_ready;
	brp_pkg::bundle_t b_data;
	brp_pkg::res_t    o_data;

	brp_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.data_byte(s_axis_tdata), .end_of_input(s_axis_tuser),
		.b_valid, .b_ready, .b_data
	);

	brp_back #(.Depth(Depth)) u_back (
		.clk, .arst_n,
		.b_valid, .b_ready, .b_data,
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_data
	);

	// pack one result item
	assign m_axis_tdata = {6'b000000, o_data.err, o_data.ch, o_data.op, o_data.value,
		o_data.fid};
	assign m_axis_tuser = o_data.kind;
	assign m_axis_tlast = o_data.last;

endmodule

// ===== test/bam_record_parser_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bam_record_parser_tb: self-checking bench for the BAM record parser
// Streams well-formed records with random content, then one stream ending
// (clean end, truncation or a layout error) chosen at random. Every accepted
// byte is run through a behavioral decoder and the results are compared in
// order with the m_axis output, under random idling and back-pressure.
// ---------------------------------------------------------------------------

typedef struct {
	brp_pkg::kind_t kind;
	logic [2:0]     fid;
	logic [31:0]    value;
	logic [3:0]     op;
	logic [7:0]     ch;
	brp_pkg::err_t  err;
	logic           last;
} brp_result_t;

class brp_scoreboard;
	brp_result_t expected[$];
	int unsigned mismatches;
	// decoder state
	brp_pkg::phase_t phase;
	bit [1:0]    byte_in_word;
	bit [31:0]   word_gather;
	bit [31:0]   block_left;
	bit [7:0]    name_length;
	bit [7:0]    name_left;
	bit [15:0]   cigar_left;
	bit [31:0]   seq_length;
	bit [31:0]   items_left;
	bit          qual_skipped;
	bit          halted;
	int          step_results;

	function void clear();
		phase = brp_pkg::PH_SIZE;
		byte_in_word = 0;
		word_gather = 0;
		block_left = 0;
		name_length = 0;
		name_left = 0;
		cigar_left = 0;
		seq_length = 0;
		items_left = 0;
		qual_skipped = 0;
		halted = 0;
		mismatches = 0;
	endfunction

	function void emit(brp_pkg::kind_t k, logic [2:0] f, logic [31:0] v, logic [3:0] o,
			logic [7:0] c, brp_pkg::err_t e);
		brp_result_t r;
		if (step_results >= 3)
			return;
		r.kind = k;
		r.fid = f;
		r.value = v;
		r.op = o;
		r.ch = c;
		r.err = e;
		r.last = 1'b0;
		expected.insert(expected.size(), r);
		step_results++;
	endfunction

	function void fail(brp_pkg::err_t e);
		emit(brp_pkg::K_ERROR, 0, 0, 0, 0, e);
		halted = 1;
	endfunction

	function void gather(bit [7:0] b);
		if (byte_in_word == 0)
			word_gather = 0;
		word_gather |= 32'(b) << (8 * byte_in_word);
	endfunction

	function void enter_tags();
		if (block_left > 0) begin
			phase = brp_pkg::PH_TAGS;
		end else begin
			emit(brp_pkg::K_REC_END, 0, 0, 0, 0, brp_pkg::E_NONE);
			phase = brp_pkg::PH_SIZE;
			byte_in_word = 0;
			word_gather = 0;
		end
	endfunction

	function void enter_seq();
		if (seq_length > 0) begin
			phase = brp_pkg::PH_SEQ;
			items_left = seq_length;
		end else begin
			emit(brp_pkg::K_QUAL_NA, 0, 0, 0, 0, brp_pkg::E_NONE);
			enter_tags();
		end
	endfunction

	function void fixed_byte(bit [7:0] b);
		bit [4:0] off;
		longint unsigned var_len;
		off = 5'(32 - items_left);
		gather(b);
		byte_in_word++;
		items_left--;
		case (off)
			5'd3:  emit(brp_pkg::K_FIXED, 0, word_gather, 0, 0, brp_pkg::E_NONE);
			5'd7:  emit(brp_pkg::K_FIXED, 1, word_gather, 0, 0, brp_pkg::E_NONE);
			5'd8:  name_length = b;
			5'd9:  emit(brp_pkg::K_FIXED, 2, 32'(b), 0, 0, brp_pkg::E_NONE);
			5'd13: cigar_left = word_gather[15:0];
			5'd15: emit(brp_pkg::K_FIXED, 3, word_gather >> 16, 0, 0, brp_pkg::E_NONE);
			5'd19: begin
				if (name_length == 0) begin
					fail(brp_pkg::E_EMPTYNAME);
					return;
				end
				if (word_gather[31]) begin
					fail(brp_pkg::E_NEGLEN);
					return;
				end
				seq_length = word_gather;
				var_len = longint'(name_length) + 4 * longint'(cigar_left)
					+ (longint'(seq_length) + 1) / 2 + longint'(seq_length);
				if (var_len + 12 > longint'(block_left))
					fail(brp_pkg::E_OVERFLOW);
			end
			5'd23: emit(brp_pkg::K_FIXED, 4, word_gather, 0, 0, brp_pkg::E_NONE);
			5'd27: emit(brp_pkg::K_FIXED, 5, word_gather, 0, 0, brp_pkg::E_NONE);
			5'd31: begin
				emit(brp_pkg::K_FIXED, 6, word_gather, 0, 0, brp_pkg::E_NONE);
				phase = brp_pkg::PH_NAME;
				name_left = name_length;
			end
			default: ;
		endcase
	endfunction

	// Work out the results of one accepted byte and queue them.
	function void note_input(bit [7:0] b, bit eoi);
		step_results = 0;
		if (halted)
			return;
		if (eoi) begin
			if (phase == brp_pkg::PH_SIZE && byte_in_word == 0) begin
				emit(brp_pkg::K_CLEAN_END, 0, 0, 0, 0, brp_pkg::E_NONE);
				halted = 1;
			end else begin
				fail(brp_pkg::E_TRUNC);
			end
		end else if (phase == brp_pkg::PH_SIZE) begin
			gather(b);
			byte_in_word++;
			if (byte_in_word == 0) begin
				if (word_gather < 32) begin
					fail(brp_pkg::E_SMALL);
				end else begin
					block_left = word_gather;
					phase = brp_pkg::PH_FIXED;
					items_left = 32;
				end
			end
		end else begin
			block_left--;
			case (phase)
				brp_pkg::PH_FIXED: fixed_byte(b);
				brp_pkg::PH_NAME: begin
					name_left--;
					if (!(name_left == 0 && b == 0))
						emit(brp_pkg::K_NAME, 0, 0, 0, b, brp_pkg::E_NONE);
					if (name_left == 0) begin
						if (cigar_left > 0) begin
							phase = brp_pkg::PH_CIGAR;
							byte_in_word = 0;
							word_gather = 0;
						end else begin
							enter_seq();
						end
					end
				end
				brp_pkg::PH_CIGAR: begin
					gather(b);
					byte_in_word++;
					if (byte_in_word == 0) begin
						if (word_gather[3:0] > 4'd8) begin
							fail(brp_pkg::E_BADOP);
						end else begin
							emit(brp_pkg::K_CIGAR, 0, word_gather >> 4, word_gather[3:0], 0,
								brp_pkg::E_NONE);
							cigar_left--;
							if (cigar_left == 0)
								enter_seq();
						end
					end
				end
				brp_pkg::PH_SEQ: begin
					emit(brp_pkg::K_BASE, 0, 0, 0, brp_pkg::base_char(b[7:4]),
						brp_pkg::E_NONE);
					items_left--;
					if (items_left > 0) begin
						emit(brp_pkg::K_BASE, 0, 0, 0, brp_pkg::base_char(b[3:0]),
							brp_pkg::E_NONE);
						items_left--;
					end
					if (items_left == 0) begin
						phase = brp_pkg::PH_QUAL;
						items_left = seq_length;
						qual_skipped = 0;
					end
				end
				brp_pkg::PH_QUAL: begin
					if (items_left == seq_length && b == brp_pkg::QUAL_NA_BYTE) begin
						emit(brp_pkg::K_QUAL_NA, 0, 0, 0, 0, brp_pkg::E_NONE);
						qual_skipped = 1;
					end else if (!qual_skipped) begin
						emit(brp_pkg::K_QUAL, 0, 0, 0, b + brp_pkg::PHRED_OFFSET,
							brp_pkg::E_NONE);
					end
					items_left--;
					if (items_left == 0)
						enter_tags();
				end
				default: begin
					if (block_left == 0)
						enter_tags();
				end
			endcase
		end
		if (step_results > 0)
			expected[$].last = 1'b1;
	endfunction

	// Compare one output item with the oldest expectation.
	function void check_result(logic [55:0] d, logic [3:0] u, logic l);
		brp_result_t e;
		if (expected.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: tdata=%h tuser=%h tlast=%b", d, u, l);
			return;
		end
		e = expected.pop_front();
		if (u !== e.kind || d[2:0] !== e.fid || d[34:3] !== e.value
				|| d[38:35] !== e.op || d[46:39] !== e.ch || d[49:47] !== e.err
				|| d[55:50] !== 6'd0 || l !== e.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch: exp kind=%0d fid=%0d val=%h op=%0d ch=%h err=%0d ",
					"last=%b | got kind=%0d fid=%0d val=%h op=%0d ch=%h err=%0d ",
					"last=%b pad=%b"},
					e.kind, e.fid, e.value, e.op, e.ch, e.err, e.last,
					u, d[2:0], d[34:3], d[38:35], d[46:39], d[49:47], l, d[55:50]);
		end
	endfunction
endclass

module bam_record_parser_tb;
	localparam int CycleLimit = 300000;

	typedef enum int {
		END_CLEAN,
		END_TRUNC,
		END_SMALL,
		END_EMPTYNAME,
		END_NEGLEN,
		END_OVERFLOW,
		END_BADOP
	} stream_end_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;
	logic        m_axis_tlast;

	brp_scoreboard decoder;
	bit [8:0]      stream[$];   // {end_of_input, byte}
	int unsigned   cycle;
	bit            hold_done;
	int unsigned   hold_left;

	bam_record_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void push_word(bit [31:0] w, int nbytes);
		for (int i = 0; i < nbytes; i++)
			stream.insert(stream.size(), {1'b0, w[8*i +: 8]});
	endfunction

	// Append one record; a flaw other than END_CLEAN corrupts it as named.
	function automatic void add_record(stream_end_t flaw, int name_len, int n_cigar,
			int seq_len, int tag_len, bit qual_na, bit [31:0] fill);
		bit [31:0] body_len;
		bit [31:0] l_seq;
		bit [31:0] op_word;
		int        bad_at;
		body_len = 32 + name_len + 4 * n_cigar + (seq_len + 1) / 2 + seq_len + tag_len;
		if (flaw == END_SMALL)
			body_len = $urandom_range(0, 31);
		else if (flaw == END_OVERFLOW)
			body_len = body_len - tag_len - $urandom_range(1, 8);
		if (body_len < 32 && flaw != END_SMALL)
			body_len = 32;
		push_word(body_len, 4);
		if (flaw == END_SMALL)
			return;
		push_word(fill, 4);                          // ref id
		push_word($urandom, 4);                      // pos
		push_word(flaw == END_EMPTYNAME ? 0 : name_len, 1);
		push_word($urandom, 1);                      // mapq
		push_word($urandom, 2);                      // bin
		push_word(n_cigar, 2);
		push_word($urandom, 2);                      // flag
		l_seq = seq_len;
		if (flaw == END_NEGLEN)
			l_seq = {1'b1, 31'($urandom)};
		push_word(l_seq, 4);
		if (flaw == END_EMPTYNAME || flaw == END_NEGLEN || flaw == END_OVERFLOW)
			return;
		push_word(~fill, 4);                         // next ref id
		push_word($urandom, 4);                      // next pos
		push_word($urandom, 4);                      // tlen
		for (int i = 0; i < name_len; i++)
			push_word((i == name_len - 1 && $urandom_range(0, 3) != 0) ? 0 : $urandom, 1);
		bad_at = (flaw == END_BADOP) ? $urandom_range(0, n_cigar - 1) : -1;
		for (int i = 0; i < n_cigar; i++) begin
			op_word = {$urandom} << 4;
			op_word[3:0] = (i == bad_at) ? 4'($urandom_range(9, 15)) :
				4'($urandom_range(0, 8));
			push_word(op_word, 4);
		end
		if (flaw == END_BADOP)
			return;
		for (int i = 0; i < (seq_len + 1) / 2; i++)
			push_word($urandom, 1);
		for (int i = 0; i < seq_len; i++)
			push_word((i == 0 && qual_na) ? 32'hFF : $urandom, 1);
		for (int i = 0; i < tag_len; i++)
			push_word($urandom, 1);
	endfunction

	function automatic void add_random_record(stream_end_t flaw);
		int name_len;
		int seq_len;
		name_len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
		seq_len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 14);
		add_record(flaw, name_len, $urandom_range(flaw == END_BADOP ? 1 : 0, 3), seq_len,
			$urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6),
			$urandom_range(0, 4) == 0, $urandom);
	endfunction

	// Offer one byte and hold it until accepted.
	task automatic send_item(bit [8:0] it);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= it[8] ? 8'($urandom) : it[7:0];
		s_axis_tuser <= it[8];
		do
			@(posedge clk);
		while (!s_axis_tready);
		decoder.note_input(it[7:0], it[8]);
	endtask

	task automatic send_stream();
		int burst;
		while (stream.size() > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && stream.size() > 0) begin
				send_item(stream.pop_front());
				burst--;
			end
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// Receiver: random stall pattern, calm stretches, one long hold-off.
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (m_axis_tvalid && m_axis_tready)
			decoder.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
		if (!hold_done && cycle == 200) begin
			hold_left <= 400;
			hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (cycle[9:8] == 2'b01) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= $urandom_range(0, 3) != 0;
		end
		if (cycle > CycleLimit) begin
			$display("bam_record_parser_tb failed");
			$finish;
		end
	end

	initial begin
		stream_end_t stop;
		decoder = new();
		decoder.clear();
		cycle = 0;
		hold_done = 1'b0;
		hold_left = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;

		// directed: extreme fields, empty sections, unavailable quality, odd length
		add_record(END_CLEAN, 1, 0, 0, 0, 1'b0, 32'hFFFF_FFFF);
		add_record(END_CLEAN, 2, 1, 3, 0, 1'b1, 32'h7FFF_FFFF);
		add_record(END_CLEAN, 3, 2, 4, 2, 1'b0, 32'h8000_0000);

		// random well-formed records, then one random stream ending
		while (stream.size() < 400)
			add_random_record(END_CLEAN);
		stop = stream_end_t'($urandom_range(END_CLEAN, END_BADOP));
		if (stop == END_CLEAN) begin
			stream.insert(stream.size(), 9'h100);
		end else if (stop == END_TRUNC) begin
			add_random_record(END_CLEAN);
			repeat ($urandom_range(1, 30)) stream.delete(stream.size() - 1);
			stream.insert(stream.size(), 9'h100);
		end else begin
			add_random_record(stop);
		end
		// bytes after the halt are dropped
		repeat (8) stream.insert(stream.size(), {1'($urandom), 8'($urandom)});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_stream();
		while (decoder.expected.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (decoder.mismatches == 0 && decoder.expected.size() == 0)
			$display("bam_record_parser_tb passed");
		else
			$display("bam_record_parser_tb failed");
		$finish;
	end
endmodule
